FILE: sv/csch_pkg.sv
`timescale 1ns / 1ps
package csch_pkg;

	localparam int MAX_PROCS = 64;
	localparam int IDX_W     = $clog2(MAX_PROCS);
	localparam int CNT_W     = $clog2(MAX_PROCS + 1);

	localparam int ID_W   = 16;
	localparam int ARR_W  = 16;
	localparam int BUR_W  = 16;
	localparam int PRIO_W = 8;
	localparam int KEY_W  = 16;
	localparam int TIME_W = 24;
	localparam int MODE_W = 2;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [MODE_W-1:0] MODE_RSV = 2'd3;

	typedef enum logic [MODE_W-1:0] {
		MODE_FCFS = 2'd0,
		MODE_SJF  = 2'd1,
		MODE_PRIO = 2'd2
	} mode_t;

	// one stored process record
	typedef struct packed {
		logic [ID_W-1:0]   pid;
		logic [ARR_W-1:0]  arr;
		logic [BUR_W-1:0]  bur;
		logic [PRIO_W-1:0] prio;
	} rec_t;

	// one table word arriving at the selector
	typedef struct packed {
		logic             clear;
		logic             valid;
		logic             done;
		logic [IDX_W-1:0] idx;
	} scan_beat_t;

	// selector verdict after a scan
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
		logic [ARR_W-1:0] min_arr;
	} sel_res_t;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
	endfunction

	function automatic logic [TIME_W-1:0] floor_sub(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		return (a > b) ? (a - b) : '0;
	endfunction

endpackage

FILE: sv/csch_if.sv
`timescale 1ns / 1ps

interface csch_rec_if import csch_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ID_W-1:0]   process_id;
	logic [ARR_W-1:0]  arrival_time;
	logic [BUR_W-1:0]  burst_time;
	logic [PRIO_W-1:0] priority_level;
	logic              last_item;

	modport source (output valid, process_id, arrival_time, burst_time, priority_level,
		last_item, input ready);
	modport sink (input valid, process_id, arrival_time, burst_time, priority_level,
		last_item, output ready);
endinterface

interface csch_res_if import csch_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ID_W-1:0]   out_process_id;
	logic [TIME_W-1:0] completion_time;
	logic [TIME_W-1:0] turnaround_time;
	logic [TIME_W-1:0] waiting_time;
	logic [TIME_W-1:0] response_time;
	logic              last_result;

	modport source (output valid, out_process_id, completion_time, turnaround_time,
		waiting_time, response_time, last_result, input ready);
	modport sink (input valid, out_process_id, completion_time, turnaround_time,
		waiting_time, response_time, last_result, output ready);
endinterface

interface csch_cfg_if import csch_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: sv/csch_sel.sv
`timescale 1ns / 1ps
module csch_sel import csch_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mode_t             mode,
	input  logic [TIME_W-1:0] cur_time,
	input  scan_beat_t        beat,
	input  rec_t              entry,
	output sel_res_t          res
);

	logic             found_q;
	logic [IDX_W-1:0] idx_q;
	logic [KEY_W-1:0] key_q;
	logic [ARR_W-1:0] arr_q;
	logic             min_v_q;
	logic [ARR_W-1:0] min_q;

	logic [KEY_W-1:0] key_new;
	logic             is_ready;
	logic             is_better;

	always_comb begin
		unique case (mode)
			MODE_SJF:  key_new = KEY_W'(entry.bur);
			MODE_PRIO: key_new = KEY_W'(entry.prio);
			default:   key_new = KEY_W'(entry.arr);
		endcase
	end

	assign is_ready  = !beat.done && (TIME_W'(entry.arr) <= cur_time);
	// primary key, then arrival; load order wins remaining ties (strict compare)
	assign is_better = !found_q ||
		((key_new != key_q) ? (key_new < key_q) : (entry.arr < arr_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			min_v_q <= 1'b0;
		end else if (beat.clear) begin
			found_q <= 1'b0;
			min_v_q <= 1'b0;
		end else if (beat.valid && !beat.done) begin
			if (is_ready && is_better) begin
				found_q <= 1'b1;
			end
			min_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (beat.valid && !beat.clear && !beat.done) begin
			if (is_ready && is_better) begin
				idx_q <= beat.idx;
				key_q <= key_new;
				arr_q <= entry.arr;
			end
			// earliest pending arrival, for the idle time jump
			if (!min_v_q || entry.arr < min_q) begin
				min_q <= entry.arr;
			end
		end
	end

	assign res.found   = found_q;
	assign res.idx     = idx_q;
	assign res.min_arr = min_q;

endmodule

FILE: sv/nonpreemptive_cpu_schedule_sim_core.sv
`timescale 1ns / 1ps
// Load: one record word per cycle into the process table.
// Schedule: per dispatched process, one table scan (a second one when the CPU
// is idle and time jumps), then a fetch of the picked record into the result.
// The single-read-port process table sets this pace; result stalls add to it.
// Reset (arst_n low, async): table empty, time and mode zero, no result pending.
module nonpreemptive_cpu_schedule_sim_core import csch_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	csch_rec_if.sink   proc_rec,
	csch_res_if.source sched_res,
	csch_cfg_if.sink   cfg
);

	typedef enum logic [4:0] {
		ST_LOAD   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_FLUSH  = 5'b00100,
		ST_DECIDE = 5'b01000,
		ST_FETCH  = 5'b10000
	} state_t;

	state_t            st_q;
	mode_t             mode_q;
	logic [CNT_W-1:0]  cnt_q;      // records loaded in this set
	logic [CNT_W-1:0]  disp_q;     // records dispatched so far
	logic [IDX_W-1:0]  scan_addr_q;
	logic [TIME_W-1:0] time_q;
	logic [MAX_PROCS-1:0] done_q;

	// process table: one write port (load), one registered read port (scan/fetch)
	rec_t mem [MAX_PROCS];
	rec_t rd_data_q;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;

	logic             v_s1;
	logic [IDX_W-1:0] idx_s1;

	// result register
	logic              res_valid_q;
	logic [ID_W-1:0]   pid_q;
	logic [TIME_W-1:0] comp_q;
	logic [TIME_W-1:0] tat_q;
	logic [TIME_W-1:0] wait_q;
	logic [TIME_W-1:0] resp_q;
	logic              last_q;

	scan_beat_t beat;
	sel_res_t   sel;

	logic rec_acc;
	logic wr_en;
	logic scan_last;
	logic disp_last;
	logic slot_free;
	logic res_load;
	logic scan_start;

	logic [TIME_W-1:0] start_t;
	logic [TIME_W-1:0] arr_t;
	logic [TIME_W-1:0] bur_t;
	logic [TIME_W-1:0] comp_t;
	logic [TIME_W-1:0] tat_t;

	//------------------------------------------------------------------
	// Handshakes
	//------------------------------------------------------------------
	assign proc_rec.ready = (st_q == ST_LOAD);
	assign rec_acc        = proc_rec.valid && proc_rec.ready;
	// a full table drops further records, but their last flag still counts
	assign wr_en          = rec_acc && (cnt_q < CNT_W'(MAX_PROCS));

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FCFS;
		end else if (cfg.valid && cfg.ready) begin
			// reserved code behaves as first come first served
			mode_q <= (cfg.data == MODE_RSV) ? MODE_FCFS : mode_t'(cfg.data);
		end
	end

	//------------------------------------------------------------------
	// Control
	//------------------------------------------------------------------
	assign scan_last = ({1'b0, scan_addr_q} == (cnt_q - CNT_W'(1)));
	assign disp_last = ((disp_q + CNT_W'(1)) == cnt_q);
	assign slot_free = !res_valid_q || sched_res.ready;
	assign res_load  = (st_q == ST_FETCH) && slot_free;

	// selector is cleared whenever a fresh scan begins
	assign scan_start = (rec_acc && proc_rec.last_item) ||
		((st_q == ST_DECIDE) && !sel.found) ||
		(res_load && !disp_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_LOAD;
			cnt_q       <= '0;
			disp_q      <= '0;
			scan_addr_q <= '0;
			time_q      <= '0;
			done_q      <= '0;
		end else begin
			unique case (st_q)
				ST_LOAD: begin
					if (wr_en) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (rec_acc && proc_rec.last_item) begin
						time_q      <= '0;
						disp_q      <= '0;
						scan_addr_q <= '0;
						st_q        <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						st_q <= ST_FLUSH;
					end else begin
						scan_addr_q <= scan_addr_q + IDX_W'(1);
					end
				end
				ST_FLUSH: begin
					st_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (sel.found) begin
						st_q <= ST_FETCH;
					end else begin
						// CPU idle: jump to earliest pending arrival and rescan
						time_q      <= TIME_W'(sel.min_arr);
						scan_addr_q <= '0;
						st_q        <= ST_SCAN;
					end
				end
				ST_FETCH: begin
					if (res_load) begin
						time_q <= comp_t;
						if (disp_last) begin
							cnt_q  <= '0;
							done_q <= '0;
							st_q   <= ST_LOAD;
						end else begin
							done_q[sel.idx] <= 1'b1;
							disp_q          <= disp_q + CNT_W'(1);
							scan_addr_q     <= '0;
							st_q            <= ST_SCAN;
						end
					end
				end
				default: st_q <= ST_LOAD;
			endcase
		end
	end

	//------------------------------------------------------------------
	// Process table
	//------------------------------------------------------------------
	assign rd_en   = (st_q == ST_SCAN) || ((st_q == ST_DECIDE) && sel.found);
	assign rd_addr = (st_q == ST_SCAN) ? scan_addr_q : sel.idx;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[IDX_W-1:0]] <= '{pid: proc_rec.process_id,
				arr: proc_rec.arrival_time, bur: proc_rec.burst_time,
				prio: proc_rec.priority_level};
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// scan word tag, aligned with the registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= (st_q == ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_addr_q;
	end

	assign beat.clear = scan_start;
	assign beat.valid = v_s1;
	assign beat.done  = done_q[idx_s1];
	assign beat.idx   = idx_s1;

	csch_sel u_sel (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (mode_q),
		.cur_time (time_q),
		.beat     (beat),
		.entry    (rd_data_q),
		.res      (sel)
	);

	//------------------------------------------------------------------
	// Result arithmetic (read data holds the picked record in ST_FETCH)
	//------------------------------------------------------------------
	assign start_t = time_q;
	assign arr_t   = TIME_W'(rd_data_q.arr);
	assign bur_t   = TIME_W'(rd_data_q.bur);
	assign comp_t  = sat_add(start_t, bur_t);
	assign tat_t   = floor_sub(comp_t, arr_t);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (sched_res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			pid_q  <= rd_data_q.pid;
			comp_q <= comp_t;
			tat_q  <= tat_t;
			wait_q <= floor_sub(tat_t, bur_t);
			resp_q <= floor_sub(start_t, arr_t);
			last_q <= disp_last;
		end
	end

	assign sched_res.valid           = res_valid_q;
	assign sched_res.out_process_id  = pid_q;
	assign sched_res.completion_time = comp_q;
	assign sched_res.turnaround_time = tat_q;
	assign sched_res.waiting_time    = wait_q;
	assign sched_res.response_time   = resp_q;
	assign sched_res.last_result     = last_q;

	//------------------------------------------------------------------
	// Assertions
	//------------------------------------------------------------------
	a_done_clear_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_LOAD) |-> (done_q == '0))
		else $error("done flags not cleared between sets");

	a_disp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_LOAD) |-> (disp_q < cnt_q))
		else $error("more dispatches than loaded records");

	a_pick_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !done_q[sel.idx])
		else $error("dispatched a finished process");

	a_time_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q != ST_LOAD) && ($past(st_q) != ST_LOAD)) |-> (time_q >= $past(time_q)))
		else $error("schedule time went backwards");

endmodule
